// ----- sv/spse_pkg.sv -----
// Shared constants, types and the deck placement function for the
// scrambled PWM slot encoder. No dependencies.
package spse_pkg;

    localparam int DECK_BITS  = 2;
    localparam int SLOT_BITS  = 4;
    localparam int LEVEL_BITS = DECK_BITS + SLOT_BITS;
    localparam int DECKS      = 1 << DECK_BITS;
    localparam int SLOTS      = 1 << SLOT_BITS;
    localparam int CHANNELS   = 6;
    localparam int SCALE      = (1 << LEVEL_BITS) - (1 << DECK_BITS) + 1;
    localparam int LO_FULL    = (1 << DECK_BITS) - 1;
    localparam int PROD_W     = 2 * LEVEL_BITS;
    localparam int CNT_W      = DECK_BITS + 1;
    localparam int IDX_W      = DECK_BITS + SLOT_BITS;

    localparam int ROW_W  = 4;
    localparam int COL_W  = 6;
    localparam int LVL_W  = 6;
    localparam int DECK_W = DECK_BITS;
    localparam int SLOT_W = SLOT_BITS;
    localparam int PAT_W  = CHANNELS;

    typedef logic [CHANNELS-1:0][DECK_BITS-1:0]              t_up_arr;
    typedef logic [CHANNELS-1:0][SLOT_BITS-1:0]              t_lo_arr;
    typedef logic [DECKS-1:0][CHANNELS-1:0][CNT_W-1:0]       t_cnt_arr;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        t_up_arr          up;
        t_lo_arr          lo;
    } t_split;

    // scrambled position of a deck
    function automatic logic [DECK_BITS-1:0] pos_of_deck(int place);
        int   prev;
        int   idx;
        int   stride;
        int   toggle;
        int   pos;
        logic done;
        logic [DECK_BITS-1:0] res;
        prev = 0;
        idx  = 0;
        done = 1'b0;
        res  = '0;
        for (stride = DECKS >> 1; stride > 0; stride = stride >> 1) begin
            toggle = 0;
            for (pos = prev >> 1; pos < DECKS; pos = pos + stride) begin
                if (!done) begin
                    if (prev != 0) begin
                        if (toggle[0] == 1'b0) begin
                            if (idx == place) begin
                                res  = pos[DECK_BITS-1:0];
                                done = 1'b1;
                            end
                            idx = idx + 1;
                        end
                        toggle = toggle + 1;
                    end else begin
                        if (idx == place) begin
                            res  = pos[DECK_BITS-1:0];
                            done = 1'b1;
                        end
                        idx = idx + 1;
                    end
                end
                prev = stride;
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/spse_pixel_if.sv -----
// Pixel pair channel: valid/ready handshake with row, column and six intensities.
// Depends on spse_pkg.
interface spse_pixel_if;
    import spse_pkg::*;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [LVL_W-1:0] red_top;
    logic [LVL_W-1:0] green_top;
    logic [LVL_W-1:0] blue_top;
    logic [LVL_W-1:0] red_bottom;
    logic [LVL_W-1:0] green_bottom;
    logic [LVL_W-1:0] blue_bottom;

    modport source (output valid, row, column, red_top, green_top, blue_top,
                    red_bottom, green_bottom, blue_bottom, input ready);
    modport sink   (input valid, row, column, red_top, green_top, blue_top,
                    red_bottom, green_bottom, blue_bottom, output ready);
endinterface

// ----- sv/spse_slot_if.sv -----
// Slot byte channel: valid/ready handshake with address, deck, slot, pattern and last flag.
// Depends on spse_pkg.
interface spse_slot_if;
    import spse_pkg::*;
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_out;
    logic [COL_W-1:0]  column_out;
    logic [DECK_W-1:0] deck;
    logic [SLOT_W-1:0] slot;
    logic [PAT_W-1:0]  pattern;
    logic              last;

    modport source (output valid, row_out, column_out, deck, slot, pattern, last,
                    input ready);
    modport sink   (input valid, row_out, column_out, deck, slot, pattern, last,
                    output ready);
endinterface

// ----- sv/spse_emit.sv -----
// Count stage and slot sequencer: forms per-position on-counts, then walks
// every deck position and slot into a registered output. Depends on spse_pkg.
module spse_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  spse_pkg::t_split     i_split,
    output logic                 o_ready,
    spse_slot_if.source          o_slot
);
    import spse_pkg::*;

    logic                  r_c_valid;
    logic [IDX_W-1:0]      r_idx;
    t_cnt_arr              r_cnt;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;

    logic                  r_o_valid;
    logic [ROW_W-1:0]      r_o_row;
    logic [COL_W-1:0]      r_o_col;
    logic [DECK_W-1:0]     r_o_deck;
    logic [SLOT_W-1:0]     r_o_slot;
    logic [PAT_W-1:0]      r_o_pat;
    logic                  r_o_last;

    t_cnt_arr              n_cnt;
    logic [PAT_W-1:0]      n_pat;
    logic [DECK_W-1:0]     cur_pos;
    logic [SLOT_W-1:0]     cur_slot;
    logic                  idx_last;
    logic                  out_take;
    logic                  load;

    always_comb begin
        n_cnt = '0;
        for (int d = 0; d < DECKS; d++) begin
            for (int k = 0; k < CHANNELS; k++) begin
                n_cnt[pos_of_deck(d)][k] = CNT_W'(i_split.up[k])
                    + CNT_W'((int'(i_split.lo[k]) >= d + 1)
                             || (int'(i_split.lo[k]) == LO_FULL));
            end
        end
    end

    assign cur_pos  = r_idx[IDX_W-1:SLOT_BITS];
    assign cur_slot = r_idx[SLOT_BITS-1:0];
    assign idx_last = (r_idx == '1);

    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            n_pat[k] = int'(cur_slot) < int'(r_cnt[cur_pos][k]);
        end
    end

    assign out_take = !r_o_valid || o_slot.ready;
    assign load     = !r_c_valid || (idx_last && out_take);
    assign o_ready  = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_idx     <= '0;
        end else if (i_valid && load) begin
            r_c_valid <= 1'b1;
            r_idx     <= '0;
        end else if (r_c_valid && out_take) begin
            r_idx <= r_idx + 1'b1;
            if (idx_last) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && load) begin
            r_cnt <= n_cnt;
            r_row <= i_split.row;
            r_col <= i_split.column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_take) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_c_valid) begin
            r_o_row  <= r_row;
            r_o_col  <= r_col;
            r_o_deck <= cur_pos;
            r_o_slot <= cur_slot;
            r_o_pat  <= n_pat;
            r_o_last <= idx_last;
        end
    end

    assign o_slot.valid      = r_o_valid;
    assign o_slot.row_out    = r_o_row;
    assign o_slot.column_out = r_o_col;
    assign o_slot.deck       = r_o_deck;
    assign o_slot.slot       = r_o_slot;
    assign o_slot.pattern    = r_o_pat;
    assign o_slot.last       = r_o_last;

endmodule

// ----- sv/scrambled_pwm_slot_encoder.sv -----
// Scrambled PWM slot encoder: one pixel pair in, one byte per deck slot out.
// The first byte passes the input, scaling, count and output registers; each pair gives 64 bytes.
// The slot sequencer sends one byte per cycle while the output is ready; the
// input and scaling stages take the next pair meanwhile.
// Reset: synchronous active-low i_rst_n clears all valid bits; no payload reset.
// Depends on spse_pkg, spse_pixel_if, spse_slot_if and spse_emit.
module scrambled_pwm_slot_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spse_pixel_if.sink   i_pix,
    spse_slot_if.source  o_slot
);
    import spse_pkg::*;

    logic                              r_a_valid;
    logic [ROW_W-1:0]                  r_a_row;
    logic [COL_W-1:0]                  r_a_col;
    logic [CHANNELS-1:0][LVL_W-1:0]    r_a_lvl;

    logic                              r_b_valid;
    t_split                            r_b_split;

    t_split                            n_b_split;
    logic                              a_ready;
    logic                              b_ready;
    logic                              e_ready;
    logic [LEVEL_BITS-1:0]             scaled [CHANNELS];

    assign b_ready     = !r_b_valid || e_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign i_pix.ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_pix.valid) begin
            r_a_row    <= i_pix.row;
            r_a_col    <= i_pix.column;
            r_a_lvl[0] <= i_pix.red_top;
            r_a_lvl[1] <= i_pix.green_top;
            r_a_lvl[2] <= i_pix.blue_top;
            r_a_lvl[3] <= i_pix.red_bottom;
            r_a_lvl[4] <= i_pix.green_bottom;
            r_a_lvl[5] <= i_pix.blue_bottom;
        end
    end

    // rescale by SCALE / 2^LEVEL_BITS and split
    always_comb begin
        logic [PROD_W-1:0] prod;
        n_b_split.row    = r_a_row;
        n_b_split.column = r_a_col;
        for (int k = 0; k < CHANNELS; k++) begin
            prod = PROD_W'(LEVEL_BITS'(r_a_lvl[k])) * PROD_W'(SCALE);
            scaled[k] = prod[PROD_W-1:LEVEL_BITS];
            n_b_split.up[k] = scaled[k][LEVEL_BITS-1:SLOT_BITS];
            n_b_split.lo[k] = scaled[k][SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_split <= n_b_split;
        end
    end

    spse_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_valid),
        .i_split (r_b_split),
        .o_ready (e_ready),
        .o_slot  (o_slot)
    );

`ifndef SYNTH
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot.valid && o_slot.ready && !o_slot.last |=> o_slot.valid)
        else $error("byte stream broke before last");

    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot.valid && o_slot.ready && !o_slot.last
        |=> o_slot.slot == SLOT_W'($past(o_slot.slot) + 1'b1))
        else $error("slot did not advance by one");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot.valid && o_slot.last |-> o_slot.slot == '1 && o_slot.deck == '1)
        else $error("last flag away from final slot");
`endif

endmodule
